// ----- hw/rtl/itil_pkg.sv -----
// ----------------------------------------------------------------------------
// itil_pkg: shared types and constants for the inverse-lookup index table
// Request/result structs, action codes, sequencer states.
// ----------------------------------------------------------------------------
package itil_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 1;
  localparam int VW = 31;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic          found;
    logic [AW-1:0] position;
    logic [CW-1:0] entry_count;
    logic          in_order;
    logic          table_full;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,     // sorted_order[i] = i
    ST_MRD_A,    // issue read of order[a], order[b]
    ST_MRD_V,    // issue read of values
    ST_MCMP,     // compare, write merge buffer
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FRD_O,    // find: read order[mid]
    ST_FRD_V,    // find: read value
    ST_FSTEP,
    ST_DONE
  } state_t;
endpackage

// ----- hw/rtl/itil_ram.sv -----
// ----------------------------------------------------------------------------
// itil_ram: generic single-write, dual-read synchronous RAM
// Read data registered.
// ----------------------------------------------------------------------------
module itil_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- hw/rtl/index_table_inverse_lookup.sv -----
// ----------------------------------------------------------------------------
// index_table_inverse_lookup: index table with arg-sorted inverse lookup
// ----------------------------------------------------------------------------
// Load, clear, and a find that cannot hit (not built, negative key, empty)
//   go straight to the result. Find: binary-search steps of order read,
//   value read, compare, then a final probe of order[lo] for equality.
// Build: an init pass writing order[i] = i, then per merge pass an order read,
//   value read and compare per element plus a per element copy back; ceil(log2(count)) passes.
// One request at a time; busy high while working. Result strobe is one cycle;
// the receiver cannot stall. Synchronous reset clears count, flags and FSM.
// ----------------------------------------------------------------------------
module index_table_inverse_lookup
  import itil_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t req,
  output logic     busy,
  output logic     done,
  output result_t  res
);
  state_t state, state_next;

  // architectural state
  logic [CW-1:0] count;
  logic          asc;
  logic          inv_ready;
  logic [VW-1:0] prev;
  request_t      cur;

  // entry store: written on load, two read ports for value compares
  logic          e_we;
  logic [AW-1:0] e_wa, e_ra, e_rb;
  logic [VW-1:0] e_wd, e_qa, e_qb;
  itil_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(VW)) u_entry (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd),
    .raddr_a(e_ra), .rdata_a(e_qa), .raddr_b(e_rb), .rdata_b(e_qb));

  // order memory and merge buffer
  logic          o_we, m_we;
  logic [AW-1:0] o_wa, o_ra, o_rb, o_wd, o_qa, o_qb;
  logic [AW-1:0] m_wa, m_ra, m_wd, m_qa, m_qb;
  itil_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW)) u_order (
    .clk, .we(o_we), .waddr(o_wa), .wdata(o_wd),
    .raddr_a(o_ra), .rdata_a(o_qa), .raddr_b(o_rb), .rdata_b(o_qb));
  itil_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW)) u_mbuf (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd),
    .raddr_a(m_ra), .rdata_a(m_qa), .raddr_b(m_ra), .rdata_b(m_qb));

  // sequencing counters (CW wide so they can reach count)
  logic [CW-1:0] width, lo, mid, hi, a, b, k, i;
  logic [CW-1:0] width_next, lo_next, mid_next, hi_next, a_next, b_next;
  logic [CW-1:0] k_next, i_next;
  logic [AW-1:0] pa, pb;  // positions latched from order reads
  logic          found_r;
  logic [AW-1:0] pos_r;
  logic          full_r;

  // load-side values
  logic [VW-1:0] ld_v;
  assign ld_v = req.value[31] ? '0 : req.value[VW-1:0];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // merge range helpers
  function automatic logic [CW-1:0] clampn(input logic [CW:0] x, input logic [CW-1:0] n);
    clampn = (x < {1'b0, n}) ? x[CW-1:0] : n;
  endfunction

  // next segment starts at the current hi
  logic [CW-1:0] nlo_mid, nlo_hi;
  assign nlo_mid = clampn({1'b0, hi} + {1'b0, width}, count);
  assign nlo_hi  = clampn({1'b0, nlo_mid} + {1'b0, width}, count);

  logic have_a, have_b, take_a;
  assign have_a = a < mid;
  assign have_b = b < hi;
  assign take_a = have_a && (!have_b || e_qa <= e_qb);

  // find: lo/hi reused as bounds, mid midpoint
  logic [CW-1:0] fmid;
  assign fmid = lo + ((hi - lo) >> 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == ACT_BUILD) begin
            state_next = (count == '0) ? ST_DONE : ST_INIT;
          end else if (req.action == ACT_FIND) begin
            if (inv_ready && !req.value[31] && count != '0) state_next = ST_FRD_O;
            else state_next = ST_DONE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_INIT:    if (i + 1'b1 == count) state_next = (count > 1) ? ST_MRD_A : ST_DONE;
      ST_MRD_A:   state_next = ST_MRD_V;
      ST_MRD_V:   state_next = ST_MCMP;
      ST_MCMP: begin
        if (k + 1'b1 == count) state_next = ST_COPY_RD;
        else state_next = ST_MRD_A;
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        if (i + 1'b1 == count) begin
          state_next = ({1'b0, width, 1'b0} < {2'b0, count}) ? ST_MRD_A : ST_DONE;
        end else begin
          state_next = ST_COPY_RD;
        end
      end
      ST_FRD_O:   state_next = ST_FRD_V;
      ST_FRD_V:   state_next = ST_FSTEP;
      ST_FSTEP:   state_next = ST_FRD_O;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
    // find exit: lo == hi after a step means final probe done
    if (state == ST_FSTEP && lo_next == hi_next && i == '1) state_next = ST_DONE;
  end

  // datapath controls
  always_comb begin
    e_we = 1'b0; e_wa = count[AW-1:0]; e_wd = ld_v;
    e_ra = pa;   e_rb = pb;
    o_we = 1'b0; o_wa = i[AW-1:0]; o_wd = i[AW-1:0];
    o_ra = a[AW-1:0]; o_rb = b[AW-1:0];
    m_we = 1'b0; m_wa = k[AW-1:0]; m_wd = take_a ? pa : pb;
    m_ra = i[AW-1:0];
    width_next = width; lo_next = lo; mid_next = mid; hi_next = hi;
    a_next = a; b_next = b; k_next = k; i_next = i;
    unique case (state)
      ST_IDLE: begin
        i_next = '0;
        if (accept && req.action == ACT_LOAD && count < CW'(MAX_ENTRIES)) e_we = 1'b1;
        if (accept && req.action == ACT_BUILD) width_next = CW'(1);
        if (accept) begin
          lo_next = '0; hi_next = count;
          a_next = '0; k_next = '0;
          mid_next = clampn({1'b0, CW'(1)}, count);
          b_next = mid_next;
          hi_next = (req.action == ACT_BUILD) ? clampn({1'b0, CW'(2)}, count) : count;
        end
      end
      ST_INIT: begin
        o_we = 1'b1;
        i_next = i + 1'b1;
      end
      ST_MRD_A: ;  // order reads issued at a, b
      ST_MRD_V: begin
        // latch happens in ff; entry reads use order data directly
        e_ra = o_qa; e_rb = o_qb;
      end
      ST_MCMP: begin
        m_we = 1'b1;
        k_next = k + 1'b1;
        if (take_a) a_next = a + 1'b1;
        else b_next = b + 1'b1;
        if (k_next == hi && k_next != count) begin
          lo_next = hi;
          mid_next = nlo_mid;
          hi_next = nlo_hi;
          a_next = hi;
          b_next = nlo_mid;
        end
        i_next = '0;
      end
      ST_COPY_RD: ;
      ST_COPY_WR: begin
        o_we = 1'b1; o_wd = m_qa;
        i_next = i + 1'b1;
        if (i + 1'b1 == count) begin
          width_next = width << 1;
          lo_next = '0; k_next = '0; a_next = '0;
          mid_next = clampn({1'b0, width_next}, count);
          b_next = mid_next;
          hi_next = clampn({1'b0, mid_next} + {1'b0, width_next}, count);
        end
      end
      ST_FRD_O: begin
        o_ra = (lo == hi) ? lo[AW-1:0] : fmid[AW-1:0];
        mid_next = (lo == hi) ? lo : fmid;
        i_next = (lo == hi) ? '1 : '0;  // final probe marker
      end
      ST_FRD_V: e_ra = o_qa;
      ST_FSTEP: begin
        if (i != '1) begin
          if (e_qa < cur.value[VW-1:0]) lo_next = mid + 1'b1;
          else hi_next = mid;
        end
      end
      default: ;
    endcase
  end

  // final probe: when lo reaches hi, read order[lo] and compare for equality;
  // lo == count means miss (order read is then ignored).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0; asc <= 1'b1; inv_ready <= 1'b0; prev <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (accept) begin
        unique case (action_t'(req.action))
          ACT_LOAD: if (count < CW'(MAX_ENTRIES)) begin
            if (count != '0 && ld_v <= prev) asc <= 1'b0;
            prev <= ld_v; count <= count + 1'b1; inv_ready <= 1'b0;
          end
          ACT_BUILD: inv_ready <= 1'b1;
          ACT_FIND:  ;
          ACT_CLEAR: begin
            count <= '0; asc <= 1'b1; inv_ready <= 1'b0; prev <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    width <= width_next; lo <= lo_next; mid <= mid_next; hi <= hi_next;
    a <= a_next; b <= b_next; k <= k_next; i <= i_next;
    if (state == ST_MRD_V) begin pa <= o_qa; pb <= o_qb; end
    if (state == ST_FRD_V) pa <= o_qa;
    if (accept) begin
      cur <= req;
      found_r <= 1'b0; pos_r <= '0;
      full_r <= (req.action == ACT_LOAD) && (count >= CW'(MAX_ENTRIES));
    end
    if (state == ST_FSTEP && i == '1 && mid < count && e_qa == cur.value[VW-1:0]
        && cur.value[31:VW] == '0) begin
      found_r <= 1'b1; pos_r <= pa;
    end
  end

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      res.found       <= found_r;
      res.position    <= pos_r;
      res.entry_count <= count;
      res.in_order    <= asc;
      res.table_full  <= full_r;
    end
  end
endmodule

// ----- test/tb_index_table_inverse_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_index_table_inverse_lookup: self-checking bench for the index table
// Drives load/build/find/clear requests with random idle gaps, predicts each
// result with a behavioral table model or a typed expectation and compares each strobed result.
// ----------------------------------------------------------------------------
module tb_index_table_inverse_lookup;
  import itil_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;  // must outlast a full-table build
  localparam int ITEM_TARGET    = 1650;

  logic     clk;
  logic     rst;
  logic     start;
  request_t req;
  logic     busy;
  logic     done;
  result_t  res;

  index_table_inverse_lookup u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .res  (res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the table
  logic [VW-1:0] tbl_value [MAX_ENTRIES];
  int unsigned   tbl_count;
  logic          tbl_ascending;
  logic          tbl_ready;
  logic [VW-1:0] tbl_last;

  result_t pending_results[$];
  int      mismatches;
  int      items_sent;
  int      quiet_cycles;
  bit      idling_on;

  // One request through the table model; returns the result it must produce.
  function automatic result_t table_step(request_t r);
    result_t       o;
    logic [VW-1:0] v;
    bit            neg;
    o   = '0;
    neg = r.value[31];
    case (action_t'(r.action))
      ACT_LOAD: begin
        if (tbl_count >= MAX_ENTRIES) begin
          o.table_full = 1'b1;
        end else begin
          v = neg ? '0 : r.value[VW-1:0];
          if (tbl_count > 0 && v <= tbl_last) tbl_ascending = 1'b0;
          tbl_value[tbl_count] = v;
          tbl_last  = v;
          tbl_count = tbl_count + 1;
          tbl_ready = 1'b0;
        end
      end
      ACT_BUILD: tbl_ready = 1'b1;
      ACT_FIND: begin
        // lowest position holding the key == stable-sort lower bound
        if (tbl_ready && !neg) begin
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_value[i] == r.value[VW-1:0]) begin
              o.found    = 1'b1;
              o.position = i[AW-1:0];
              break;
            end
          end
        end
      end
      default: begin
        tbl_count     = 0;
        tbl_ascending = 1'b1;
        tbl_ready     = 1'b0;
        tbl_last      = '0;
      end
    endcase
    o.entry_count = tbl_count[CW-1:0];
    o.in_order    = tbl_ascending;
    return o;
  endfunction

  // Present one request, hold it until taken, then queue what it must return.
  // A typed expectation, when given, replaces the model's.
  task automatic issue(request_t r, bit typed, result_t typed_res);
    result_t predicted;
    if (idling_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predicted = table_step(r);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // result check; the receiver cannot stall so every strobe is a result
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res);
      end else begin
        want = pending_results.pop_front();
        if (res.found !== want.found || res.position !== want.position ||
            res.entry_count !== want.entry_count || res.in_order !== want.in_order ||
            res.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, res);
        end
      end
    end
  end

  // watchdog: a quiet stretch reaching WATCHDOG_LIMIT, with no request taken and no result, ends the run
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_index_table_inverse_lookup: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // directed rows: action, value, typed?, expected result
  typedef struct {
    action_t     act;
    logic [31:0] val;
    bit          typed;
    result_t     want;
  } directed_row_t;

  function automatic result_t mk(bit f, int p, int c, bit o, bit full);
    result_t x;
    x.found       = f;
    x.position    = p[AW-1:0];
    x.entry_count = c[CW-1:0];
    x.in_order    = o;
    x.table_full  = full;
    return x;
  endfunction

  function automatic logic [31:0] load_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(0, 63);
    if (sel < 75) return {1'b0, tbl_last} + $urandom_range(1, 1000);  // keeps ascending
    if (sel < 90) return $urandom;
    return 32'h8000_0000 | $urandom;  // negative, stored as zero
  endfunction

  function automatic logic [31:0] find_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60 && tbl_count > 0) return {1'b0, tbl_value[$urandom_range(0, tbl_count - 1)]};
    if (sel < 80) return $urandom_range(0, 70);
    return $urandom;
  endfunction

  initial begin
    directed_row_t rows[$];
    request_t      r;
    int            n_loads;
    int            n_finds;
    bit            big_done;
    bit            big_pass;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    mismatches = 0;
    items_sent = 0;
    quiet_cycles = 0;
    idling_on  = 1'b1;
    big_done   = 1'b0;
    big_pass   = 1'b0;
    tbl_count = 0; tbl_ascending = 1'b1; tbl_ready = 1'b0; tbl_last = '0;

    rows = '{
      '{ACT_FIND,  32'd5,         1, mk(0, 0, 0, 1, 0)},  // find before any build
      '{ACT_BUILD, 32'd0,         1, mk(0, 0, 0, 1, 0)},  // build of empty table
      '{ACT_FIND,  32'd0,         1, mk(0, 0, 0, 1, 0)},  // empty table always misses
      '{ACT_LOAD,  32'hFFFF_FFF9, 1, mk(0, 0, 1, 1, 0)},  // negative load, first load
      '{ACT_LOAD,  32'h7FFF_FFFF, 1, mk(0, 0, 2, 1, 0)},
      '{ACT_LOAD,  32'd3,         1, mk(0, 0, 3, 0, 0)},  // order broken
      '{ACT_LOAD,  32'd3,         1, mk(0, 0, 4, 0, 0)},  // duplicate
      '{ACT_LOAD,  32'hFFFF_FFFF, 1, mk(0, 0, 5, 0, 0)},  // zero again
      '{ACT_FIND,  32'd3,         1, mk(0, 0, 5, 0, 0)},  // not built yet
      '{ACT_BUILD, 32'd0,         1, mk(0, 0, 5, 0, 0)},
      '{ACT_FIND,  32'd0,         1, mk(1, 0, 5, 0, 0)},  // lowest duplicate
      '{ACT_FIND,  32'd3,         1, mk(1, 2, 5, 0, 0)},
      '{ACT_FIND,  32'h7FFF_FFFF, 1, mk(1, 1, 5, 0, 0)},
      '{ACT_FIND,  32'hFFFF_FFFB, 1, mk(0, 0, 5, 0, 0)},  // negative key
      '{ACT_FIND,  32'h8000_0000, 1, mk(0, 0, 5, 0, 0)},
      '{ACT_FIND,  32'd4,         1, mk(0, 0, 5, 0, 0)},  // miss
      '{ACT_LOAD,  32'd9,         0, '0},                 // stale inverse
      '{ACT_FIND,  32'd3,         1, mk(0, 0, 6, 0, 0)},
      '{ACT_CLEAR, 32'd0,         1, mk(0, 0, 0, 1, 0)},
      '{ACT_LOAD,  32'd10,        0, '0},
      '{ACT_LOAD,  32'd11,        0, '0},
      '{ACT_BUILD, 32'd0,         0, '0},
      '{ACT_FIND,  32'd11,        0, '0},
      '{ACT_CLEAR, 32'hFFFF_FFFF, 0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r.action = rows[i].act;
      r.value  = rows[i].val;
      issue(r, rows[i].typed, rows[i].want);
    end

    // random request sequences: clear, fill, build, search; with some noise
    while (items_sent < ITEM_TARGET) begin
      idling_on = !(items_sent >= 700 && items_sent < 950);
      if ($urandom_range(99) < 70) begin
        r.action = ACT_CLEAR; r.value = $urandom;
        issue(r, 0, '0);
      end
      if (!big_done && items_sent > 100) begin
        n_loads  = MAX_ENTRIES + 3;  // one full-table pass with dropped loads
        big_done = 1'b1;
        big_pass = 1'b1;
      end else begin
        n_loads  = $urandom_range(0, 40);
        big_pass = 1'b0;
      end
      for (int i = 0; i < n_loads; i++) begin
        // no noise in the full-table pass so the table really fills
        if (!big_pass && $urandom_range(99) < 6) begin
          r.action = 2'($urandom_range(0, 3)); r.value = $urandom;
        end else begin
          r.action = ACT_LOAD; r.value = load_value();
        end
        issue(r, 0, '0);
      end
      if ($urandom_range(99) < 85) begin
        r.action = ACT_BUILD; r.value = $urandom;
        issue(r, 0, '0);
      end
      n_finds = $urandom_range(1, 10);
      for (int i = 0; i < n_finds; i++) begin
        r.action = ACT_FIND; r.value = find_key();
        issue(r, 0, '0);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_index_table_inverse_lookup: done, clean");
    end else begin
      $display("tb_index_table_inverse_lookup: done, errors");
    end
    $finish;
  end
endmodule
